[rtl/lkvc_pkg.sv]
// lkvc_pkg: shared item types, opcodes and controller/datapath link structs
`timescale 1ns / 1ps

package lkvc_pkg;

  // operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // value returned on a lookup miss
  localparam logic signed [31:0] MISS_VALUE = -32'sd1;

  // capacity register width and reset value
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] lookup_key;
    logic signed [31:0] store_value;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
  } out_item_t;

  // commands from the controller
  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
    logic emit;
  } ctl_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic scan_done;
    logic op_put;
    logic out_blocked;
  } dp_stat_t;

endpackage

[rtl/lkvc_ctrl.sv]
// lkvc_ctrl: sequencing state machine for accept, key scan, update and result
`timescale 1ns / 1ps

module lkvc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lkvc_pkg::dp_stat_t stat,
  output lkvc_pkg::ctl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = stat.op_put ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_blocked) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

[rtl/lkvc_dp.sv]
// lkvc_dp: key/value memories, recency ranks, scan compare and result register
`timescale 1ns / 1ps

module lkvc_dp #(
  parameter int ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lkvc_pkg::in_item_t           in_data,
  input  logic [lkvc_pkg::CAP_W-1:0]   cap_r,
  input  lkvc_pkg::ctl_cmd_t           cmd,
  output lkvc_pkg::dp_stat_t           stat,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lkvc_pkg::out_item_t          out_data
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int WW = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;

  // held item
  lkvc_pkg::in_item_t item_r;

  // storage
  logic [31:0]        keys_mem [ENTRIES];
  logic [31:0]        vals_mem [ENTRIES];
  logic               valid_r  [ENTRIES];
  logic [ENTRIES-1:0] valid_nxt;
  logic [IW-1:0]      rank_r   [ENTRIES];
  logic [IW-1:0]      rank_nxt [ENTRIES];
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;

  // scan pipeline
  logic [CW-1:0] scan_cnt_r;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [31:0]   key_rd_r;
  logic          cmp_vld_r;
  logic [IW-1:0] cmp_idx_r;
  logic          hit_found_r;
  logic [IW-1:0] hit_idx_r;
  logic [IW-1:0] hit_rank_r;
  logic          free_found_r;
  logic [IW-1:0] free_idx_r;
  logic [IW-1:0] victim_idx_r;
  logic          cmp_valid;
  logic          key_match;
  logic          is_victim;

  // update controls
  logic [WW-1:0] eff_cap;
  logic          full;
  logic          do_touch;
  logic          do_insert;
  logic          drop;
  logic          use_victim;
  logic [IW-1:0] slot;
  logic [IW-1:0] wr_addr;
  logic [31:0]   val_rd_r;

  // result register
  logic                out_valid_r;
  lkvc_pkg::out_item_t out_data_r;

  // item capture on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
  end

  // scan address counter
  assign rd_en   = cmd.scan && (scan_cnt_r < CW'(ENTRIES));
  assign rd_addr = scan_cnt_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      cmp_vld_r  <= 1'b0;
    end else if (cmd.load) begin
      scan_cnt_r <= '0;
      cmp_vld_r  <= 1'b0;
    end else begin
      cmp_vld_r <= rd_en;
      if (rd_en) begin
        scan_cnt_r <= scan_cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cmp_idx_r <= rd_addr;
    end
  end

  // key memory
  always_ff @(posedge clk) begin
    if (do_insert) begin
      keys_mem[slot] <= item_r.lookup_key;
    end
    if (rd_en) begin
      key_rd_r <= keys_mem[rd_addr];
    end
  end

  // per-entry compare stage
  assign cmp_valid = cmp_vld_r && valid_r[cmp_idx_r];
  assign key_match = cmp_valid && (key_rd_r == item_r.lookup_key);
  assign is_victim = cmp_valid && (CW'(rank_r[cmp_idx_r]) == (count_r - CW'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.load) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      if (key_match && !hit_found_r) begin
        hit_found_r <= 1'b1;
      end
      if (cmp_vld_r && !valid_r[cmp_idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_match && !hit_found_r) begin
      hit_idx_r  <= cmp_idx_r;
      hit_rank_r <= rank_r[cmp_idx_r];
    end
    if (cmp_vld_r && !valid_r[cmp_idx_r] && !free_found_r) begin
      free_idx_r <= cmp_idx_r;
    end
    if (is_victim) begin
      victim_idx_r <= cmp_idx_r;
    end
  end

  // effective capacity, clamped to one .. ENTRIES
  always_comb begin
    eff_cap = WW'(cap_r);
    if (cap_r == '0) begin
      eff_cap = WW'(1);
    end else if (WW'(cap_r) > WW'(ENTRIES)) begin
      eff_cap = WW'(ENTRIES);
    end
  end

  assign full       = WW'(count_r) >= eff_cap;
  assign do_touch   = cmd.apply && hit_found_r;
  assign do_insert  = cmd.apply && !hit_found_r && (item_r.opcode == lkvc_pkg::OP_PUT);
  assign drop       = do_insert && full;
  assign use_victim = drop && (!free_found_r || (victim_idx_r < free_idx_r));
  assign slot       = use_victim ? victim_idx_r : free_idx_r;
  assign wr_addr    = hit_found_r ? hit_idx_r : slot;

  // value memory
  always_ff @(posedge clk) begin
    if (cmd.apply && (item_r.opcode == lkvc_pkg::OP_PUT)) begin
      vals_mem[wr_addr] <= item_r.store_value;
    end
    if (do_touch && (item_r.opcode == lkvc_pkg::OP_GET)) begin
      val_rd_r <= vals_mem[hit_idx_r];
    end
  end

  // valid and rank update
  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < ENTRIES; i++) begin
      valid_nxt[i] = valid_r[i];
      rank_nxt[i]  = rank_r[i];
      if (do_touch) begin
        if (IW'(i) == hit_idx_r) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (rank_r[i] < hit_rank_r)) begin
          rank_nxt[i] = rank_r[i] + IW'(1);
        end
      end else if (do_insert) begin
        if (IW'(i) == slot) begin
          valid_nxt[i] = 1'b1;
          rank_nxt[i]  = '0;
        end else if (drop && (IW'(i) == victim_idx_r)) begin
          valid_nxt[i] = 1'b0;
          rank_nxt[i]  = '0;
        end else if (valid_r[i]) begin
          rank_nxt[i] = rank_r[i] + IW'(1);
        end
      end
    end
    if (do_insert && !drop) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
        rank_r[i]  <= '0;
      end
    end else begin
      count_r <= count_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= valid_nxt[i];
        rank_r[i]  <= rank_nxt[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.hit        <= hit_found_r;
      out_data_r.read_value <= hit_found_r ? val_rd_r : lkvc_pkg::MISS_VALUE;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status to the controller
  assign stat.scan_done   = (scan_cnt_r == CW'(ENTRIES)) && !cmp_vld_r;
  assign stat.op_put      = (item_r.opcode == lkvc_pkg::OP_PUT);
  assign stat.out_blocked = out_valid_r && out_stall;

  // occupancy never exceeds the store size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("occupancy above store size");

  // occupancy tracks the valid bits
  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_nxt) == int'(count_nxt))
    else $error("occupancy and valid bits disagree");

  // a recorded hit always points at a live entry
  a_hit_live: assert property (@(posedge clk) disable iff (!rst_n)
    hit_found_r |-> valid_r[hit_idx_r])
    else $error("hit index points at an empty slot");

  // a new result only ever follows an emit command
  a_out_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.emit))
    else $error("result appeared without emit");

endmodule

[rtl/lru_key_value_cache_unit.sv]
// lru_key_value_cache_unit: top level of the fully associative LRU key-value store
// a get scans every key, is applied, then registers its result in the emit state
// the next input is taken in idle, after apply for a put or after emit for a get
// the serial key scan reads one entry per cycle over the key memory port
// synchronous active-low reset empties the store and sets the capacity to 16
// key and value memories are not cleared; entries are guarded by per-slot valid bits
`timescale 1ns / 1ps

module lru_key_value_cache_unit #(
  parameter int ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lkvc_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output lkvc_pkg::out_item_t        out_data,
  input  logic                       cfg_wr_en,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data
);

  logic [lkvc_pkg::CAP_W-1:0] cap_r;
  lkvc_pkg::ctl_cmd_t         cmd;
  lkvc_pkg::dp_stat_t         stat;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkvc_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // sequencer
  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and compare datapath
  lkvc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cap_r     (cap_r),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[sim/lru_key_value_cache_unit_checker.sv]
// lru_key_value_cache_unit_checker: watches the cache channels, predicts each read and compares
`timescale 1ns / 1ps

module lru_key_value_cache_unit_checker #(
  parameter int ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  lkvc_pkg::in_item_t         in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  lkvc_pkg::out_item_t        out_data,
  input  logic                       cfg_wr_en,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data,
  output int                         pending_reads,
  output int                         failures
);

  // shadow copy of the store
  logic [31:0]                slot_key [ENTRIES];
  logic [31:0]                slot_val [ENTRIES];
  logic                       slot_live[ENTRIES];
  int unsigned                slot_age [ENTRIES];
  int unsigned                live_n;
  logic [lkvc_pkg::CAP_W-1:0] cap_reg;

  // read results still owed by the block, oldest first
  lkvc_pkg::out_item_t expected_reads[$];

  lkvc_pkg::out_item_t want;
  int                  hit_slot;
  int                  fail_n;

  function automatic int find_slot(input logic [31:0] key);
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      if (slot_live[i] && slot_key[i] == key) return i;
    end
    return -1;
  endfunction

  // entry becomes newest, everything newer than it ages by one
  function automatic void make_newest(input int e);
    int unsigned r;
    int i;
    r = slot_age[e];
    for (i = 0; i < ENTRIES; i++) begin
      if (slot_live[i] && slot_age[i] < r) slot_age[i]++;
    end
    slot_age[e] = 0;
  endfunction

  function automatic void drop_oldest();
    int i;
    int worst;
    worst = -1;
    for (i = 0; i < ENTRIES; i++) begin
      if (slot_live[i] && (worst < 0 || slot_age[i] > slot_age[worst])) worst = i;
    end
    if (worst >= 0) begin
      slot_live[worst] = 1'b0;
      slot_age[worst]  = 0;
      live_n--;
    end
  endfunction

  // new key: evict when at capacity, then fill the lowest free slot
  function automatic void insert_entry(input logic [31:0] key, input logic [31:0] val);
    int unsigned cap_eff;
    int i;
    int slot;
    cap_eff = cap_reg;
    if (cap_eff == 0) cap_eff = 1;
    if (cap_eff > ENTRIES) cap_eff = ENTRIES;
    if (live_n >= cap_eff) drop_oldest();
    slot = -1;
    for (i = 0; i < ENTRIES; i++) begin
      if (!slot_live[i]) begin
        if (slot < 0) slot = i;
      end else begin
        slot_age[i]++;
      end
    end
    if (slot >= 0) begin
      slot_live[slot] = 1'b1;
      slot_key[slot]  = key;
      slot_val[slot]  = val;
      slot_age[slot]  = 0;
      live_n++;
    end
  endfunction

  always @(posedge clk) begin : watch
    int i;
    if (!rst_n) begin
      for (i = 0; i < ENTRIES; i++) begin
        slot_live[i] = 1'b0;
        slot_age[i]  = 0;
      end
      live_n  = 0;
      cap_reg = lkvc_pkg::CAP_RESET;
      expected_reads.delete();
    end else begin
      // result transfer against the oldest outstanding read
      if (out_valid && !out_stall) begin
        if (expected_reads.size() == 0) begin
          $display("%0t: unexpected read result, expected none, got hit %0b value %h",
                   $time, out_data.hit, out_data.read_value);
          fail_n++;
        end else begin
          want = expected_reads.pop_front();
          if (out_data.hit !== want.hit) begin
            $display("%0t: hit mismatch, expected %0b got %0b",
                     $time, want.hit, out_data.hit);
            fail_n++;
          end
          if (out_data.read_value !== want.read_value) begin
            $display("%0t: read_value mismatch, expected %h got %h",
                     $time, want.read_value, out_data.read_value);
            fail_n++;
          end
        end
      end
      // capacity register write
      if (cfg_wr_en) cap_reg = cfg_wr_data;
      // input transfer updates the shadow store
      if (in_valid && !in_stall) begin
        hit_slot = find_slot(in_data.lookup_key);
        if (in_data.opcode == lkvc_pkg::OP_GET) begin
          if (hit_slot >= 0) begin
            make_newest(hit_slot);
            want.hit        = 1'b1;
            want.read_value = slot_val[hit_slot];
          end else begin
            want.hit        = 1'b0;
            want.read_value = lkvc_pkg::MISS_VALUE;
          end
          expected_reads.push_back(want);
        end else if (hit_slot >= 0) begin
          slot_val[hit_slot] = in_data.store_value;
          make_newest(hit_slot);
        end else begin
          insert_entry(in_data.lookup_key, in_data.store_value);
        end
      end
    end
    pending_reads <= expected_reads.size();
    failures      <= fail_n;
  end

endmodule

[sim/lru_key_value_cache_unit_tb.sv]
// lru_key_value_cache_unit_tb: stimulus, flow control and verdict for the LRU key-value cache
`timescale 1ns / 1ps

module lru_key_value_cache_unit_tb;

  localparam int ENTRIES     = 16;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int POOL_N      = 24;

  logic                       clk         = 1'b0;
  logic                       rst_n       = 1'b0;
  logic                       in_valid    = 1'b0;
  logic                       in_stall;
  lkvc_pkg::in_item_t         in_data     = '0;
  logic                       out_valid;
  logic                       out_stall   = 1'b0;
  lkvc_pkg::out_item_t        out_data;
  logic                       cfg_wr_en   = 1'b0;
  logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data = lkvc_pkg::CAP_RESET;

  int   pending_reads;
  int   failures;
  int   sent_count = 0;
  int   cycles     = 0;
  logic quiet      = 1'b0;

  // receiver flow control state
  int   stall_left = 0;
  int   hold_left  = 0;
  logic hold_done  = 1'b0;

  logic [31:0]                key_pool[POOL_N];
  logic [lkvc_pkg::CAP_W-1:0] cap_now;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  lru_key_value_cache_unit #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  lru_key_value_cache_unit_checker #(
    .ENTRIES(ENTRIES)
  ) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .pending_reads(pending_reads),
    .failures     (failures)
  );

  // count input transfers, used to time the long hold-off
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sent_count <= sent_count + 1;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_count >= 80) begin
      out_stall <= 1'b1;
      hold_left <= 399;
      hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // offer one item, with an occasional gap before it, and wait for its transfer
  task automatic send(input logic op, input logic [31:0] key, input logic [31:0] val);
    lkvc_pkg::in_item_t item;
    item.opcode      = op;
    item.lookup_key  = key;
    item.store_value = val;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering and let every outstanding read and any put in flight finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reads != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_now = cap;
  endtask

  // mostly keys from a pool sized to the capacity so hits and evictions both occur
  function automatic logic [31:0] pick_key();
    int top_idx;
    top_idx = cap_now + 4;
    if (top_idx > POOL_N - 1) top_idx = POOL_N - 1;
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_pool[$urandom_range(0, top_idx)];
  endfunction

  task automatic random_phase(input logic [lkvc_pkg::CAP_W-1:0] cap, input int n);
    settle();
    set_capacity(cap);
    repeat (n) begin
      send($urandom_range(0, 1) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET, pick_key(), $urandom);
    end
  endtask

  initial begin
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_N; i++) key_pool[i] = $urandom;
    cap_now = lkvc_pkg::CAP_RESET;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // capacity one: miss on empty store, then every new key replaces the last
    set_capacity(5'd1);
    send(lkvc_pkg::OP_GET, 32'h8000_0000, $urandom);
    send(lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send(lkvc_pkg::OP_GET, 32'h8000_0000, $urandom);
    send(lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send(lkvc_pkg::OP_GET, 32'h8000_0000, $urandom);
    send(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, $urandom);

    // full capacity: extreme keys and values, overwrite, plain miss
    settle();
    set_capacity(5'd16);
    send(lkvc_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send(lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h5555_5555);
    send(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, $urandom);
    send(lkvc_pkg::OP_GET, 32'h0000_0000, $urandom);
    send(lkvc_pkg::OP_PUT, 32'h0000_0000, 32'h1234_5678);
    send(lkvc_pkg::OP_GET, 32'h0000_0000, $urandom);
    send(lkvc_pkg::OP_GET, 32'd42, $urandom);
    send(lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'hAAAA_AAAA);

    // capacity lowered below occupancy: new keys replace, store does not shrink
    settle();
    set_capacity(5'd2);
    send(lkvc_pkg::OP_PUT, 32'd7, 32'd70);
    send(lkvc_pkg::OP_PUT, 32'd8, 32'd80);
    send(lkvc_pkg::OP_GET, 32'd7, $urandom);
    send(lkvc_pkg::OP_GET, 32'h8000_0000, $urandom);
    send(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, $urandom);
    send(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, $urandom);

    // random traffic over a range of capacities
    random_phase(5'd3, 120);
    random_phase(5'd6, 120);
    random_phase(5'd10, 120);
    random_phase(5'd16, 120);
    random_phase(5'd1, 120);
    random_phase(5'($urandom_range(1, 16)), 120);
    random_phase(5'($urandom_range(1, 16)), 120);
    random_phase(5'd13, 120);

    // last stretch runs without idling on either side
    settle();
    quiet <= 1'b1;
    random_phase(5'd16, 120);

    settle();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
